// File: src/fdl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fdl_pkg;

	// Default sizes of the delay line
	localparam int DEPTH_DEF       = 65536;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF   = 16;

	// Fixed field widths
	localparam int CFG_W   = 17;
	localparam int CNT_W   = 48;
	localparam int CNT_IW  = 6;
	localparam int WHOLE_W = 48;

	// Ring length limits and reset value
	localparam int RING_MIN   = 8;
	localparam int RING_RESET = 65536;

	// Guard bits of the interpolation coefficients above the fraction
	localparam int COEF_GUARD = 3;

	// Operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

endpackage

`default_nettype wire

// File: src/fdl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fdl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: src/fdl_coef.sv
`timescale 1ns / 1ps
`default_nettype none

// Six-stage pipeline for the four cubic Lagrange weights of a fraction.
module fdl_coef #(
	parameter int FRAC_BITS = fdl_pkg::FRAC_BITS_DEF,
	localparam int CW = FRAC_BITS + fdl_pkg::COEF_GUARD
) (
	input  wire logic                 clk,
	input  wire logic [FRAC_BITS-1:0] frac,
	output logic signed [CW-1:0]      c0_s6,
	output logic signed [CW-1:0]      c1_s6,
	output logic signed [CW-1:0]      c2_s6,
	output logic signed [CW-1:0]      c3_s6
);

	localparam int FB  = FRAC_BITS;
	localparam int BW  = FB + 3;
	localparam int PW  = 2 * BW;
	localparam int NW  = FB + 3;
	localparam int K   = NW + 2;
	localparam int PRD = NW + K;
	localparam logic signed [BW-1:0] SV    = BW'(1) << FB;
	localparam logic        [PW-1:0] HALF  = PW'(1) << (FB - 1);
	localparam logic        [PW-1:0] ONE_S = PW'(1) << FB;
	localparam logic        [PW-1:0] TRI_S = PW'(3) << FB;
	localparam logic        [K-1:0]  MAGIC = K'(((longint'(1) << K) + 2) / 3);

	function automatic logic [PW-1:0] mag(input logic signed [PW-1:0] x);
		logic [PW-1:0] m;
		m = x[PW-1] ? PW'(-x) : PW'(x);
		return m;
	endfunction

	function automatic logic signed [PW-1:0] rnd_s(input logic signed [PW-1:0] x);
		logic [PW-1:0] q;
		q = (mag(x) + HALF) >> FB;
		return x[PW-1] ? -$signed(q) : $signed(q);
	endfunction

	logic [FB-1:0] a_s1, a_s2;
	logic signed [PW-1:0] ph_s1, pg_s1;
	logic signed [BW-1:0] h_s2, g_s2;
	logic signed [PW-1:0] m0_s3, m1_s3, m2_s3, m3_s3;
	logic [NW-1:0] n0_s4, n1_s4, n2_s4, n3_s4;
	logic [3:0] neg_s4, neg_s5;
	logic [NW-1:0] q0_s5, q1_s5, q2_s5, q3_s5;

	logic signed [BW-1:0] ax0, ax2;
	logic signed [PW-1:0] h_c, g_c;
	logic [PRD-1:0] t0_c, t3_c;

	assign ax0 = $signed(BW'(frac));
	assign ax2 = $signed(BW'(a_s2));
	assign h_c = rnd_s(ph_s1);
	assign g_c = rnd_s(pg_s1);
	assign t0_c = (PRD'(n0_s4) * PRD'(MAGIC)) >> K;
	assign t3_c = (PRD'(n3_s4) * PRD'(MAGIC)) >> K;

	always_ff @(posedge clk) begin
		// products of the node distances
		a_s1  <= frac;
		ph_s1 <= ax0 * (ax0 - SV);
		pg_s1 <= (ax0 + SV) * (ax0 - (SV <<< 1));
		// scale back by one fraction unit
		a_s2 <= a_s1;
		h_s2 <= h_c[BW-1:0];
		g_s2 <= g_c[BW-1:0];
		// weight numerators
		m0_s3 <= -(h_s2 * (ax2 - (SV <<< 1)));
		m1_s3 <= g_s2 * (ax2 - SV);
		m2_s3 <= -(g_s2 * ax2);
		m3_s3 <= h_s2 * (ax2 + SV);
		// round halves; the outer weights keep a further third to take
		n0_s4  <= NW'((mag(m0_s3) + TRI_S) >> (FB + 1));
		n1_s4  <= NW'((mag(m1_s3) + ONE_S) >> (FB + 1));
		n2_s4  <= NW'((mag(m2_s3) + ONE_S) >> (FB + 1));
		n3_s4  <= NW'((mag(m3_s3) + TRI_S) >> (FB + 1));
		neg_s4 <= {m3_s3[PW-1], m2_s3[PW-1], m1_s3[PW-1], m0_s3[PW-1]};
		// divide by three through the reciprocal
		q0_s5  <= t0_c[NW-1:0];
		q1_s5  <= n1_s4;
		q2_s5  <= n2_s4;
		q3_s5  <= t3_c[NW-1:0];
		neg_s5 <= neg_s4;
		// restore signs
		c0_s6 <= neg_s5[0] ? -$signed(CW'(q0_s5)) : $signed(CW'(q0_s5));
		c1_s6 <= neg_s5[1] ? -$signed(CW'(q1_s5)) : $signed(CW'(q1_s5));
		c2_s6 <= neg_s5[2] ? -$signed(CW'(q2_s5)) : $signed(CW'(q2_s5));
		c3_s6 <= neg_s5[3] ? -$signed(CW'(q3_s5)) : $signed(CW'(q3_s5));
	end

endmodule

`default_nettype wire

// File: src/fractional_delay_line_lagrange_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencing: a write is taken while idle, and writes may follow back to back. A read in the
//   window passes the window check, four sequential sample-memory reads, the serial
//   multiply-accumulate, rounding and saturation; one outside the window ends at the check.
// After a ring length write the block is busy while the write slot is reduced bit by bit
//   modulo the new length. Reset clears all control state and then sweeps zeros through
//   the sample memory with busy high. The receiver cannot stall results.
module fractional_delay_line_lagrange_top #(
	parameter int DEPTH       = fdl_pkg::DEPTH_DEF,
	parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// item command
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                operation,
	input  wire logic signed [SAMPLE_BITS-1:0]       sample_in,
	input  wire logic signed [fdl_pkg::WHOLE_W-1:0]  read_whole,
	input  wire logic        [FRAC_BITS-1:0]         read_frac,
	// result strobe
	output logic                                     result_valid,
	output logic signed [SAMPLE_BITS-1:0]            read_value,
	output logic                                     in_window,
	// ring length register
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [fdl_pkg::CFG_W-1:0]           cfg_data
);

	localparam int SB  = SAMPLE_BITS;
	localparam int FB  = FRAC_BITS;
	localparam int AW  = $clog2(DEPTH);
	localparam int LB  = $clog2(DEPTH + 1);
	localparam int XW  = (LB > fdl_pkg::CFG_W) ? LB : fdl_pkg::CFG_W;
	localparam int WW  = fdl_pkg::CNT_W + 2;
	localparam int CW  = FB + fdl_pkg::COEF_GUARD;
	localparam int PRW = CW + SB;
	localparam int ACW = PRW + 2;
	localparam int VW  = ACW - FB + 1;
	localparam logic [LB-1:0] RST_LEN =
		LB'((fdl_pkg::RING_RESET > DEPTH) ? DEPTH : fdl_pkg::RING_RESET);
	localparam logic [ACW-1:0] RHALF = ACW'(1) << (FB - 1);
	localparam logic signed [VW-1:0] VMAX = VW'((longint'(1) << (SB - 1)) - 1);
	localparam logic signed [VW-1:0] VMIN = -VMAX - VW'(1);

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_REM, ST_CHK1, ST_CHK2, ST_ADDR,
		ST_RD, ST_WAITY, ST_MUL, ST_RND, ST_SAT
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_cnt_q;
	logic [fdl_pkg::CNT_W-1:0] wc_q;
	logic [AW-1:0] wslot_q;
	logic [LB-1:0] len_q;
	logic pend_q;
	logic [LB-1:0] rem_r_q;
	logic [fdl_pkg::CNT_IW-1:0] rem_i_q;
	logic signed [fdl_pkg::WHOLE_W-1:0] whole_q;
	logic [FB-1:0] frac_q;
	logic lo_ok_q;
	logic [LB-1:0] d_q;
	logic [AW-1:0] slot_q;
	logic [2:0] cnt_q;
	logic signed [SB-1:0] y_q [4];
	logic rv_s1;
	logic [1:0] ridx_s1;
	logic signed [PRW-1:0] prod_q;
	logic signed [ACW-1:0] acc_q;
	logic signed [VW-1:0] v_q;

	logic item_fire, cfg_fire;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [SB-1:0] ram_wdata, ram_rdata;
	logic signed [CW-1:0] c0, c1, c2, c3, c_sel;
	logic [XW-1:0] cx, lenc;
	logic [LB:0] rem_rr, rem_nx;
	logic [WW-1:0] wcs, wx, lx;
	logic hi_ok;
	logic signed [LB:0] sd;
	logic [AW-1:0] slot0, slot_inc, wslot_inc;
	logic [ACW-1:0] acc_mag, acc_q_rnd;

	assign busy      = (state_q != ST_IDLE) || pend_q;
	assign cfg_ready = (state_q != ST_REM);
	assign item_fire = start && !busy;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// Clamp the ring length to the memory size and the minimum
	assign cx   = XW'(cfg_data);
	assign lenc = (cx < XW'(fdl_pkg::RING_MIN)) ? XW'(fdl_pkg::RING_MIN) :
	              (cx > XW'(DEPTH)) ? XW'(DEPTH) : cx;

	// Memory write: zero sweep after reset, otherwise the sample of a write transaction
	assign ram_we    = (state_q == ST_CLR) || (item_fire && operation == fdl_pkg::OP_WRITE);
	assign ram_waddr = (state_q == ST_CLR) ? clr_cnt_q : wslot_q;
	assign ram_wdata = (state_q == ST_CLR) ? '0 : sample_in;

	fdl_ram #(
		.WIDTH(SB),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(slot_q),
		.rdata(ram_rdata)
	);

	fdl_coef #(
		.FRAC_BITS(FB)
	) u_coef (
		.clk  (clk),
		.frac (frac_q),
		.c0_s6(c0),
		.c1_s6(c1),
		.c2_s6(c2),
		.c3_s6(c3)
	);

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    c_sel = c0;
			2'd1:    c_sel = c1;
			2'd2:    c_sel = c2;
			default: c_sel = c3;
		endcase
	end

	// One restoring step of the write count modulo the ring length
	assign rem_rr = {rem_r_q, wc_q[rem_i_q]};
	assign rem_nx = (rem_rr >= (LB+1)'(len_q)) ? rem_rr - (LB+1)'(len_q) : rem_rr;

	// Window arithmetic on the absolute position
	assign wcs   = WW'(wc_q);
	assign wx    = WW'(whole_q);
	assign lx    = WW'(len_q);
	assign hi_ok = $signed(wx + WW'(3)) <= $signed(wcs);

	// First tap: step back from the write slot by the distance, wrap once
	assign sd    = $signed((LB+1)'(wslot_q)) - $signed((LB+1)'(d_q));
	assign slot0 = sd[LB] ? AW'(sd + $signed((LB+1)'(len_q))) : AW'(sd);

	assign slot_inc  = ((LB'(slot_q) + LB'(1)) == len_q) ? '0 : slot_q + AW'(1);
	assign wslot_inc = ((LB'(wslot_q) + LB'(1)) == len_q) ? '0 : wslot_q + AW'(1);

	// Round the accumulator back to sample scale, ties away from zero
	assign acc_mag   = acc_q[ACW-1] ? ACW'(-acc_q) : ACW'(acc_q);
	assign acc_q_rnd = (acc_mag + RHALF) >> FB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_cnt_q    <= '0;
			wc_q         <= '0;
			wslot_q      <= '0;
			len_q        <= RST_LEN;
			pend_q       <= 1'b0;
			rem_i_q      <= '0;
			cnt_q        <= '0;
			rv_s1        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			rv_s1        <= 1'b0;

			// Take the ring length; the write slot is recomputed from idle
			if (cfg_fire) begin
				len_q  <= LB'(lenc);
				pend_q <= 1'b1;
			end

			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pend_q) begin
						if (!cfg_fire) begin
							pend_q <= 1'b0;
						end
						rem_r_q <= '0;
						rem_i_q <= fdl_pkg::CNT_IW'(fdl_pkg::CNT_W - 1);
						state_q <= ST_REM;
					end else if (item_fire) begin
						if (operation == fdl_pkg::OP_WRITE) begin
							// advance the count; a count wrap restarts at slot zero
							wc_q    <= wc_q + fdl_pkg::CNT_W'(1);
							wslot_q <= (&wc_q) ? '0 : wslot_inc;
						end else begin
							whole_q <= read_whole;
							frac_q  <= read_frac;
							state_q <= ST_CHK1;
						end
					end
				end
				ST_REM: begin
					rem_r_q <= rem_nx[LB-1:0];
					rem_i_q <= rem_i_q - fdl_pkg::CNT_IW'(1);
					if (rem_i_q == '0) begin
						wslot_q <= AW'(rem_nx[LB-1:0]);
						state_q <= ST_IDLE;
					end
				end
				ST_CHK1: begin
					lo_ok_q <= $signed(wx) >= $signed(wcs - lx + WW'(1));
					state_q <= ST_CHK2;
				end
				ST_CHK2: begin
					d_q <= LB'(wcs - wx + WW'(1));
					if (lo_ok_q && hi_ok) begin
						state_q <= ST_ADDR;
					end else begin
						// drop the read: a tap lies outside the written window
						read_value   <= '0;
						in_window    <= 1'b0;
						result_valid <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				ST_ADDR: begin
					slot_q  <= slot0;
					cnt_q   <= '0;
					acc_q   <= '0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					slot_q  <= slot_inc;
					rv_s1   <= 1'b1;
					ridx_s1 <= cnt_q[1:0];
					cnt_q   <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						cnt_q   <= '0;
						state_q <= ST_WAITY;
					end
				end
				ST_WAITY: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (cnt_q != 3'd4) begin
						prod_q <= c_sel * y_q[cnt_q[1:0]];
					end
					if (cnt_q != 3'd0) begin
						acc_q <= acc_q + ACW'(prod_q);
					end
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					v_q     <= acc_q[ACW-1] ? -$signed(VW'(acc_q_rnd)) : $signed(VW'(acc_q_rnd));
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					if (v_q > VMAX) begin
						read_value <= VMAX[SB-1:0];
					end else if (v_q < VMIN) begin
						read_value <= VMIN[SB-1:0];
					end else begin
						read_value <= v_q[SB-1:0];
					end
					in_window    <= 1'b1;
					result_valid <= 1'b1;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold each tap as it leaves the memory
	always_ff @(posedge clk) begin
		if (rv_s1) begin
			y_q[ridx_s1] <= $signed(ram_rdata);
		end
	end

endmodule

`default_nettype wire

// File: src/fdl_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module fdl_chk #(
	parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   start,
	input wire logic                   busy,
	input wire logic                   operation,
	input wire logic                   result_valid,
	input wire logic [SAMPLE_BITS-1:0] read_value,
	input wire logic                   in_window
);

	// A result outside the window carries zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !in_window) |-> (read_value == '0))
		else $error("out-of-window result is not zero");

	// A read transaction keeps the block busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == fdl_pkg::OP_READ) |=> busy)
		else $error("read transaction did not raise busy");

	// A write transaction gives no result
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == fdl_pkg::OP_WRITE) |=> !result_valid)
		else $error("write transaction produced a result");

	// Results never come in consecutive cycles
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for more than one cycle");

endmodule

bind fractional_delay_line_lagrange_top fdl_chk #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_fdl_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.operation   (operation),
	.result_valid(result_valid),
	.read_value  (read_value),
	.in_window   (in_window)
);

`default_nettype wire
